// ===== hdl/rsl_pkg.sv =====
`timescale 1ns / 1ps

package rsl_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int LUM_BITS_DEF   = 16;

    // squared radius beyond which the flat far factor applies
    localparam int FAR_D2      = 25600;
    localparam int D2_BITS     = 15;

    // distance in unsigned Q.8, square root taken one bit per stage
    localparam int DIST_FRAC   = 8;
    localparam int ROOT_BITS   = 16;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int SQ_REM_BITS = ROOT_BITS + 2;

    // falloff span 200 in Q.8, far factor 0.2 of the span
    localparam int FACTOR_BITS = 16;
    localparam int SPAN_Q      = 51200;
    localparam int FAR_FACTOR  = 10240;

    // span split into a power of two and an odd part, 51200 = 25 << 11
    localparam int SPAN_SHIFT  = 11;
    localparam int SPAN_ODD    = 25;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_COL = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_ROW = 2'd1;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hdl/rsl_front.sv =====
`timescale 1ns / 1ps

module rsl_front import rsl_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LUM_BITS   = LUM_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [CFG_ADDR_BITS-1:0]         cfg_addr,
    input  logic [COORD_BITS:0]              cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [COORD_BITS-1:0]            s_pixel_col,
    input  logic [COORD_BITS-1:0]            s_pixel_row,
    input  logic [LUM_BITS-1:0]              s_lum_in,
    input  q_status_t                        q_status,
    output logic                             q_push,
    output logic [1+D2_BITS+LUM_BITS-1:0]    q_item
);

    localparam int DXW = COORD_BITS + 1;
    localparam int DFW = COORD_BITS + 2;
    localparam int SQW = 2 * DXW;
    localparam int SMW = SQW + 1;

    logic [COORD_BITS:0] ccol_reg;
    logic [COORD_BITS:0] crow_reg;

    logic                f1_valid_reg;
    logic [DXW-1:0]      f1_dx_reg;
    logic [DXW-1:0]      f1_dy_reg;
    logic [LUM_BITS-1:0] f1_lum_reg;

    logic                f2_valid_reg;
    logic [SQW-1:0]      f2_sqx_reg;
    logic [SQW-1:0]      f2_sqy_reg;
    logic [LUM_BITS-1:0] f2_lum_reg;

    logic                f3_valid_reg;
    logic                f3_far_reg;
    logic [D2_BITS-1:0]  f3_d2_reg;
    logic [LUM_BITS-1:0] f3_lum_reg;

    logic                en;
    logic [DFW-1:0]      diff_col;
    logic [DFW-1:0]      diff_row;
    logic [DXW-1:0]      f1_dx_next;
    logic [DXW-1:0]      f1_dy_next;
    logic [SMW-1:0]      d2_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ccol_reg <= '0;
            crow_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_CENTER_COL: ccol_reg <= cfg_data;
                REG_CENTER_ROW: crow_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !(f3_valid_reg && q_status.full);
    assign s_ready = en;
    assign q_push  = f3_valid_reg && en;
    assign q_item  = {f3_far_reg, f3_d2_reg, f3_lum_reg};

    // signed distance to the centre, then magnitude
    assign diff_col = {2'b00, s_pixel_col} - {ccol_reg[COORD_BITS], ccol_reg};
    assign diff_row = {2'b00, s_pixel_row} - {crow_reg[COORD_BITS], crow_reg};

    assign f1_dx_next = diff_col[DFW-1] ? DXW'(-diff_col) : diff_col[DXW-1:0];
    assign f1_dy_next = diff_row[DFW-1] ? DXW'(-diff_row) : diff_row[DXW-1:0];

    assign d2_sum = SMW'(f2_sqx_reg) + SMW'(f2_sqy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= s_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_dx_reg  <= f1_dx_next;
            f1_dy_reg  <= f1_dy_next;
            f1_lum_reg <= s_lum_in;
            f2_sqx_reg <= f1_dx_reg * f1_dx_reg;
            f2_sqy_reg <= f1_dy_reg * f1_dy_reg;
            f2_lum_reg <= f1_lum_reg;
            f3_far_reg <= d2_sum > SMW'(FAR_D2);
            f3_d2_reg  <= d2_sum[D2_BITS-1:0];
            f3_lum_reg <= f2_lum_reg;
        end
    end

endmodule

// ===== hdl/rsl_queue.sv =====
`timescale 1ns / 1ps

module rsl_queue import rsl_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output q_status_t        status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign status.full  = count_reg == CNT_W'(DEPTH);
    assign status.empty = count_reg == '0;
    assign rd_data      = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/rsl_back.sv =====
`timescale 1ns / 1ps

module rsl_back import rsl_pkg::*; #(
    parameter int LUM_BITS = LUM_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  q_status_t                     q_status,
    input  logic [1+D2_BITS+LUM_BITS-1:0] q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [LUM_BITS-1:0]           m_lum_out
);

    localparam int PROD_W = LUM_BITS + FACTOR_BITS;
    localparam int RSW    = SQ_REM_BITS + 2;
    localparam int X_W    = PROD_W - SPAN_SHIFT;
    localparam int RCP_SH = X_W + $clog2(SPAN_ODD);
    localparam int RCP_W  = X_W + 1;
    localparam int RP_W   = X_W + RCP_W;
    localparam longint unsigned RCP_M = ((64'd1 << RCP_SH) + SPAN_ODD - 1) / SPAN_ODD;

    logic en;

    // square root stages
    logic                   sq_valid_reg [0:ROOT_BITS];
    logic                   sq_far_reg   [0:ROOT_BITS];
    logic [D2_BITS-1:0]     sq_d2_reg    [0:ROOT_BITS];
    logic [LUM_BITS-1:0]    sq_lum_reg   [0:ROOT_BITS];
    logic [SQ_REM_BITS-1:0] sq_rem_reg   [0:ROOT_BITS];
    logic [ROOT_BITS-1:0]   sq_root_reg  [0:ROOT_BITS];
    logic [SQ_REM_BITS-1:0] sq_rem_next  [1:ROOT_BITS];
    logic [ROOT_BITS-1:0]   sq_root_next [1:ROOT_BITS];

    // scale factor and product
    logic                   fac_valid_reg;
    logic [FACTOR_BITS-1:0] fac_reg;
    logic [LUM_BITS-1:0]    fac_lum_reg;
    logic [FACTOR_BITS-1:0] fac_next;
    logic                   prod_valid_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;

    // division by the span
    logic                   out_valid_reg;
    logic [LUM_BITS-1:0]    out_lum_reg;
    logic [RP_W-1:0]        recip_prod;

    assign en        = !out_valid_reg || m_ready;
    assign q_pop     = en && !q_status.empty;
    assign m_valid   = out_valid_reg;
    assign m_lum_out = out_lum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (en) begin
            sq_valid_reg[0] <= !q_status.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_far_reg[0]  <= q_item[D2_BITS+LUM_BITS];
            sq_d2_reg[0]   <= q_item[LUM_BITS +: D2_BITS];
            sq_lum_reg[0]  <= q_item[LUM_BITS-1:0];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sq
        logic [RAD_BITS-1:0] rad;
        logic [1:0]          pair;
        logic [RSW-1:0]      rem_sh;
        logic [RSW-1:0]      trial;

        assign rad    = RAD_BITS'(sq_d2_reg[k]) << (2 * DIST_FRAC);
        assign pair   = rad[RAD_BITS-1-2*k -: 2];
        assign rem_sh = {sq_rem_reg[k], pair};
        assign trial  = RSW'({sq_root_reg[k], 2'b01});

        always_comb begin
            if (rem_sh >= trial) begin
                sq_rem_next[k+1]  = SQ_REM_BITS'(rem_sh - trial);
                sq_root_next[k+1] = {sq_root_reg[k][ROOT_BITS-2:0], 1'b1};
            end else begin
                sq_rem_next[k+1]  = SQ_REM_BITS'(rem_sh);
                sq_root_next[k+1] = {sq_root_reg[k][ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_far_reg[k+1]  <= sq_far_reg[k];
                sq_d2_reg[k+1]   <= sq_d2_reg[k];
                sq_lum_reg[k+1]  <= sq_lum_reg[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k+1];
                sq_root_reg[k+1] <= sq_root_next[k+1];
            end
        end
    end

    // near: span minus distance, far: fixed fifth of the span
    assign fac_next  = sq_far_reg[ROOT_BITS] ? FACTOR_BITS'(FAR_FACTOR)
                                             : FACTOR_BITS'(SPAN_Q) - sq_root_reg[ROOT_BITS];
    assign prod_next = PROD_W'(fac_lum_reg) * PROD_W'(fac_reg);

    // drop the power of two, then multiply by the rounded-up reciprocal of the odd part
    assign recip_prod = RP_W'(prod_reg[PROD_W-1:SPAN_SHIFT]) * RP_W'(RCP_W'(RCP_M));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fac_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (en) begin
            fac_valid_reg  <= sq_valid_reg[ROOT_BITS];
            prod_valid_reg <= fac_valid_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fac_reg     <= fac_next;
            fac_lum_reg <= sq_lum_reg[ROOT_BITS];
            prod_reg    <= prod_next;
            out_lum_reg <= recip_prod[RCP_SH +: LUM_BITS];
        end
    end

endmodule

// ===== hdl/radial_spotlight_luminance_core.sv =====
`timescale 1ns / 1ps

// Radial spotlight luminance falloff. Each pixel transfer carries a column, a row and an
// unsigned Q0.LUM_BITS luminance; the result is the luminance scaled by (1 - d/200), d being
// the distance from the programmed centre in Q.8 (truncated), or by 0.2 beyond a distance of
// 160, and the centre pixel passes unchanged. One pixel is taken every clock and one result
// leaves every clock when nothing stalls, since the 16-stage square root and the reciprocal
// scaling are fully pipelined. A pixel passes 3 front registers, one queue entry, 17 square
// root registers and 3 scale registers before its result is valid. The front stalls only
// when the queue is full; the back stalls only on output backpressure.
// Registers: index 0 center_col, index 1 center_row, both signed COORD_BITS+1 bits, reset 0;
// writes to other indexes are ignored. Write the centre only while no pixel is in flight.

module radial_spotlight_luminance_core import rsl_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LUM_BITS   = LUM_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COORD_BITS:0]      cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [COORD_BITS-1:0]    s_pixel_col,
    input  logic [COORD_BITS-1:0]    s_pixel_row,
    input  logic [LUM_BITS-1:0]      s_lum_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [LUM_BITS-1:0]      m_lum_out
);

    localparam int ITEM_W = 1 + D2_BITS + LUM_BITS;

    q_status_t         q_status;
    logic              q_push;
    logic              q_pop;
    logic [ITEM_W-1:0] q_wr_item;
    logic [ITEM_W-1:0] q_rd_item;

    assign cfg_ready = 1'b1;

    rsl_front #(
        .COORD_BITS (COORD_BITS),
        .LUM_BITS   (LUM_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_col (s_pixel_col),
        .s_pixel_row (s_pixel_row),
        .s_lum_in    (s_lum_in),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_item      (q_wr_item)
    );

    rsl_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_item),
        .pop     (q_pop),
        .rd_data (q_rd_item),
        .status  (q_status)
    );

    rsl_back #(
        .LUM_BITS (LUM_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .q_item    (q_rd_item),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_lum_out (m_lum_out)
    );

endmodule
